[src/apbb_pkg.sv]
// Shared types and constants of the arc path bounding box block.
`default_nettype none

package apbb_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned OffsW  = 31;
  localparam int unsigned SqW    = 2 * OffsW;
  localparam int unsigned RootW  = OffsW;
  localparam int unsigned AngW   = 18;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [AngW-1:0]   angle_t;

  // Segment kind codes; the unused code behaves like a straight line.
  localparam logic [1:0] KIND_LINE = 2'd0;
  localparam logic [1:0] KIND_CW   = 2'd1;
  localparam logic [1:0] KIND_CCW  = 2'd2;

  // Angles in 1/64 degree.
  localparam angle_t ANG_0    = 18'sd0;
  localparam angle_t ANG_90   = 18'sd5760;
  localparam angle_t ANG_180  = 18'sd11520;
  localparam angle_t ANG_270  = 18'sd17280;
  localparam angle_t ANG_360  = 18'sd23040;
  localparam angle_t ANG_450  = 18'sd28800;
  localparam angle_t ANG_540  = 18'sd34560;
  localparam angle_t ANG_630  = 18'sd40320;
  localparam angle_t ANG_M90  = -18'sd5760;
  localparam angle_t ANG_M180 = -18'sd11520;
  localparam angle_t ANG_M270 = -18'sd17280;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } box_t;

  typedef struct packed {
    logic   load;
    logic   merge;
    coord_t load_x;
    coord_t load_y;
    coord_t pt_x;
    coord_t pt_y;
  } box_cmd_t;

endpackage

`default_nettype wire

[src/apbb_if.sv]
// Valid/ready channel interfaces for segments in and boxes out.
`default_nettype none

interface apbb_seg_if;
  logic               valid;
  logic               ready;
  logic               first_segment;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic        [1:0]  segment_kind;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [30:0] offset_i;
  logic signed [30:0] offset_j;
  logic        [14:0] begin_angle;
  logic signed [15:0] sweep_angle;

  modport source (
    output valid, first_segment, start_x, start_y, end_x, end_y, segment_kind,
           center_x, center_y, offset_i, offset_j, begin_angle, sweep_angle,
    input  ready
  );
  modport sink (
    input  valid, first_segment, start_x, start_y, end_x, end_y, segment_kind,
           center_x, center_y, offset_i, offset_j, begin_angle, sweep_angle,
    output ready
  );
endinterface

interface apbb_box_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;

  modport source (
    output valid, box_min_x, box_min_y, box_max_x, box_max_y,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_max_x, box_max_y,
    output ready
  );
endinterface

`default_nettype wire

[src/apbb_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
`default_nettype none

module apbb_isqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [apbb_pkg::SqW-1:0]  radicand_i,
  output logic                           done_o,
  output logic [apbb_pkg::RootW-1:0]     root_o
);
  import apbb_pkg::*;

  localparam int unsigned RemW = RootW + 2;
  localparam int unsigned TryW = RemW + 2;
  localparam int unsigned CntW = $clog2(RootW);

  logic [SqW-1:0]   rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [TryW-1:0] rem_sh;
  logic [TryW-1:0] trial;
  logic [TryW-1:0] diff;

  always_comb begin
    rem_sh = {rem_q, rad_q[SqW-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    diff   = rem_sh - trial;

    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(RootW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[SqW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = diff[RemW-1:0];
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[RemW-1:0];
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[src/apbb_box.sv]
// Running bounding box registers with reload and point merge.
`default_nettype none

module apbb_box (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire apbb_pkg::box_cmd_t cmd_i,
  output apbb_pkg::box_t          box_o
);
  import apbb_pkg::*;

  box_t box_q, box_d, base;

  always_comb begin
    base = box_q;
    if (cmd_i.load) begin
      base.min_x = cmd_i.load_x;
      base.max_x = cmd_i.load_x;
      base.min_y = cmd_i.load_y;
      base.max_y = cmd_i.load_y;
    end
    box_d = base;
    if (cmd_i.merge) begin
      if (cmd_i.pt_x < base.min_x) box_d.min_x = cmd_i.pt_x;
      if (cmd_i.pt_y < base.min_y) box_d.min_y = cmd_i.pt_y;
      if (cmd_i.pt_x > base.max_x) box_d.max_x = cmd_i.pt_x;
      if (cmd_i.pt_y > base.max_y) box_d.max_y = cmd_i.pt_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else begin
      box_q <= box_d;
    end
  end

  assign box_o = box_q;

endmodule

`default_nettype wire

[src/arc_path_bounding_box_core.sv]
// Top level of the arc path bounding box block: sequencer and shared datapath.
//
// Usage: one path segment is taken per transaction on seg_i and one box
// (least and greatest x and y, signed Q20.12) is given per segment on box_o.
// seg_i.ready is high only while the sequencer is idle; one segment is worked
// on at a time.
// A straight line passes through capture, start reload and end point merge,
// and result load on its way from acceptance to the box on box_o. For an arc, the
// shared 31 x 31 multiplier squares the two centre offsets one after the
// other, the iterative square root unit then gives one radius bit per cycle,
// and the shared saturating adder forms one quadrant extreme point per cycle
// for the four quadrants before the result is loaded.
// The result sits in an output register, so the next segment is taken while a
// box waits; if the receiver stalls with a box still pending, the sequencer
// holds the finished box until the output register frees.
// Reset clears the running box to zero and empties the output register.
`default_nettype none

module arc_path_bounding_box_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  apbb_seg_if.sink    seg_i,
  apbb_box_if.source  box_o
);
  import apbb_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MERGE = 7'b0000010,
    ST_SQ_I  = 7'b0000100,
    ST_SQ_J  = 7'b0001000,
    ST_ROOT  = 7'b0010000,
    ST_POINT = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  localparam int unsigned SumW = CoordW + 2;

  state_e state_q, state_d;

  // Captured segment.
  logic             first_q;
  logic             arc_q;
  logic [3:0]       flags_q;
  coord_t           sx_q, sy_q, ex_q, ey_q, cx_q, cy_q;
  logic [OffsW-1:0] ai_q, aj_q;
  logic [SqW-1:0]   sq_q;
  logic [1:0]       pt_q;

  // Output register.
  logic out_valid_q, out_valid_d;
  box_t out_box_q;

  logic       seg_fire;
  logic       out_fire;
  logic       out_free;
  angle_t     ang_b, ang_e;
  logic [3:0] flags_cw, flags_ccw, flags_new;
  logic       arc_new;
  logic [OffsW-1:0] abs_i, abs_j;

  logic [OffsW-1:0] mul_a;
  logic [SqW-1:0]   prod;

  logic             sq_start;
  logic             sq_done;
  logic [RootW-1:0] root;

  logic signed [SumW-1:0] add_base, add_rad, add_sum;
  coord_t                 sat_val;

  box_cmd_t cmd;
  box_t     box_cur;

  assign seg_fire = seg_i.valid && seg_i.ready;
  assign out_fire = out_valid_q && box_o.ready;
  assign out_free = !out_valid_q || box_o.ready;
  assign seg_i.ready = (state_q == ST_IDLE);

  // Quadrant crossing tests on the exact end angle.
  always_comb begin
    ang_b = angle_t'({3'b000, seg_i.begin_angle});
    ang_e = ang_b + angle_t'(seg_i.sweep_angle);

    flags_cw[0] = (ang_e <= ANG_0);
    flags_cw[1] = (ang_b > ANG_90  && ang_e < ANG_90)  || (ang_e <= ANG_M270);
    flags_cw[2] = (ang_b > ANG_180 && ang_e < ANG_180) || (ang_e <= ANG_M180);
    flags_cw[3] = (ang_b > ANG_270 && ang_e < ANG_270) || (ang_e <= ANG_M90);

    flags_ccw[0] = (ang_e >= ANG_360);
    flags_ccw[1] = (ang_b < ANG_90  && ang_e > ANG_90)  || (ang_e >= ANG_450);
    flags_ccw[2] = (ang_b < ANG_180 && ang_e > ANG_180) || (ang_e >= ANG_540);
    flags_ccw[3] = (ang_b < ANG_270 && ang_e > ANG_270) || (ang_e >= ANG_630);

    arc_new   = (seg_i.segment_kind == KIND_CW) || (seg_i.segment_kind == KIND_CCW);
    flags_new = (seg_i.segment_kind == KIND_CW) ? flags_cw : flags_ccw;

    abs_i = seg_i.offset_i[OffsW-1] ? OffsW'(-seg_i.offset_i) : OffsW'(seg_i.offset_i);
    abs_j = seg_i.offset_j[OffsW-1] ? OffsW'(-seg_i.offset_j) : OffsW'(seg_i.offset_j);
  end

  // Shared multiplier squares one offset per cycle.
  assign mul_a    = (state_q == ST_SQ_I) ? ai_q : aj_q;
  assign prod     = SqW'(mul_a) * SqW'(mul_a);
  assign sq_start = (state_q == ST_SQ_J);

  apbb_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_q + prod),
    .done_o     (sq_done),
    .root_o     (root)
  );

  // Shared saturating adder: quadrant k gives centre plus or minus radius.
  always_comb begin
    add_base = pt_q[0] ? SumW'(cy_q) : SumW'(cx_q);
    add_rad  = SumW'({1'b0, root});
    add_sum  = pt_q[1] ? (add_base - add_rad) : (add_base + add_rad);
    if (add_sum > SumW'(coord_t'({1'b0, {(CoordW-1){1'b1}}}))) begin
      sat_val = {1'b0, {(CoordW-1){1'b1}}};
    end else if (add_sum < SumW'(coord_t'({1'b1, {(CoordW-1){1'b0}}}))) begin
      sat_val = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      sat_val = add_sum[CoordW-1:0];
    end
  end

  always_comb begin
    cmd.load   = 1'b0;
    cmd.merge  = 1'b0;
    cmd.load_x = sx_q;
    cmd.load_y = sy_q;
    cmd.pt_x   = ex_q;
    cmd.pt_y   = ey_q;
    case (state_q)
      ST_MERGE: begin
        cmd.load  = first_q;
        cmd.merge = 1'b1;
      end
      ST_POINT: begin
        cmd.merge = flags_q[pt_q];
        cmd.pt_x  = pt_q[0] ? cx_q : sat_val;
        cmd.pt_y  = pt_q[0] ? sat_val : cy_q;
      end
      default: begin
      end
    endcase
  end

  apbb_box u_box (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .box_o  (box_cur)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_fire;
    case (state_q)
      ST_IDLE: begin
        if (seg_fire) state_d = ST_MERGE;
      end
      ST_MERGE: begin
        state_d = arc_q ? ST_SQ_I : ST_DONE;
      end
      ST_SQ_I: begin
        state_d = ST_SQ_J;
      end
      ST_SQ_J: begin
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_done) state_d = ST_POINT;
      end
      ST_POINT: begin
        if (pt_q == 2'd3) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pt_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_POINT) begin
        pt_q <= pt_q + 1'b1;
      end else begin
        pt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_fire) begin
      first_q <= seg_i.first_segment;
      arc_q   <= arc_new;
      flags_q <= flags_new;
      sx_q    <= seg_i.start_x;
      sy_q    <= seg_i.start_y;
      ex_q    <= seg_i.end_x;
      ey_q    <= seg_i.end_y;
      cx_q    <= seg_i.center_x;
      cy_q    <= seg_i.center_y;
      ai_q    <= abs_i;
      aj_q    <= abs_j;
    end
    if (state_q == ST_SQ_I) begin
      sq_q <= prod;
    end
    if (state_q == ST_DONE && out_free) begin
      out_box_q <= box_cur;
    end
  end

  assign box_o.valid     = out_valid_q;
  assign box_o.box_min_x = out_box_q.min_x;
  assign box_o.box_min_y = out_box_q.min_y;
  assign box_o.box_max_x = out_box_q.max_x;
  assign box_o.box_max_y = out_box_q.max_y;

endmodule

`default_nettype wire
